[rtl/core/rle2_pkg.sv]
// Shared types and constants for the 2bpp run-length pixel placer.
// Used by rle2_advance and rle_2bpp_interlaced_pixel_placer; depends on nothing.
package rle2_pkg;

  localparam int unsigned CoordW = 12;
  localparam int unsigned CfgW   = 10;
  localparam int unsigned RowsW  = 11;
  localparam int unsigned IdxW   = 3;

  localparam logic [IdxW-1:0] REG_X_OFFSET     = 3'd0;
  localparam logic [IdxW-1:0] REG_Y_OFFSET     = 3'd1;
  localparam logic [IdxW-1:0] REG_ROW_WIDTH    = 3'd2;
  localparam logic [IdxW-1:0] REG_ROW_COUNT    = 3'd3;
  localparam logic [IdxW-1:0] REG_PIXEL_DOUBLE = 3'd4;

  localparam logic [CfgW-1:0] ROW_WIDTH_RESET = 10'd280;
  localparam logic [CfgW-1:0] ROW_COUNT_RESET = 10'd158;

  localparam logic [7:0] CTRL_REPEAT_BIT = 8'h80;
  localparam logic [7:0] CTRL_LEN_MASK   = 8'h7f;

  typedef enum logic [1:0] {
    PH_CONTROL,
    PH_REPEAT,
    PH_LITERAL
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIRST,
    ST_SECOND,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic signed [CfgW-1:0] x_offset;
    logic [CfgW-1:0]        y_offset;
    logic [CfgW-1:0]        row_width;
    logic [CfgW-1:0]        row_count;
    logic                   pixel_double;
  } cfg_t;

  typedef struct packed {
    logic signed [CoordW-1:0] cx;
    logic [CoordW-1:0]        cy;
    logic [RowsW-1:0]         rows_done;
    logic [1:0]               field_wraps;
  } cursor_t;

endpackage

[rtl/core/rle2_advance.sv]
// Cursor step unit: moves the placement cursor by one byte of pixels,
// wrapping rows and interlaced fields. Depends on rle2_pkg.
module rle2_advance (
  input  rle2_pkg::cfg_t    cfg,
  input  rle2_pkg::cursor_t cur,
  output rle2_pkg::cursor_t nxt
);

  logic signed [rle2_pkg::CoordW:0] x_step;
  logic signed [rle2_pkg::CoordW:0] x_moved;
  logic signed [rle2_pkg::CoordW:0] x_limit;
  logic                             row_end;
  logic [rle2_pkg::RowsW:0]         rows_inc;
  logic signed [rle2_pkg::CoordW-1:0] x_left;

  assign x_left  = rle2_pkg::CoordW'(cfg.x_offset);
  assign x_step  = cfg.pixel_double ? 13'sd8 : 13'sd4;
  assign x_moved = (rle2_pkg::CoordW+1)'(cur.cx) + x_step;
  assign x_limit = $signed({3'b000, cfg.row_width}) + (rle2_pkg::CoordW+1)'(cfg.x_offset);
  assign row_end = (x_moved >= x_limit);
  assign rows_inc = {1'b0, cur.rows_done} + {{rle2_pkg::RowsW{1'b0}}, row_end};

  always_comb begin
    nxt.cx          = row_end ? x_left : x_moved[rle2_pkg::CoordW-1:0];
    nxt.cy          = row_end ? cur.cy + 12'd2 : cur.cy;
    nxt.rows_done   = rows_inc[rle2_pkg::RowsW-1:0];
    nxt.field_wraps = cur.field_wraps;
    // Passing the row count starts the other field one line down.
    if (rows_inc > {2'b00, cfg.row_count}) begin
      nxt.cy          = {2'b00, cfg.y_offset} + 12'd1;
      nxt.rows_done   = '0;
      nxt.field_wraps = (cur.field_wraps == 2'd3) ? 2'd3 : cur.field_wraps + 2'd1;
    end
  end

endmodule

[rtl/core/rle_2bpp_interlaced_pixel_placer.sv]
// Top level of the 2bpp run-length decoder and interlaced pixel placer.
// Depends on rle2_pkg and rle2_advance.
// Each data byte's placements pass through ST_FIRST, then ST_SECOND for a pair, and are offered
// in ST_OUT. The single cursor step unit handles one placement per cycle while no result waits
// in ST_OUT for out_ready; a result carries up to two placements. A new byte, control or data, is
// accepted only in ST_IDLE, after the last result of the previous data byte has been transferred.
// Reset (synchronous): config to defaults, cursor to the origin, decoder expects a control byte.
module rle_2bpp_interlaced_pixel_placer (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [7:0]                           data_byte,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [7:0]                           pattern,
  output logic signed [rle2_pkg::CoordW-1:0]   first_x,
  output logic [rle2_pkg::CoordW-1:0]          first_y,
  output logic signed [rle2_pkg::CoordW-1:0]   second_x,
  output logic [rle2_pkg::CoordW-1:0]          second_y,
  output logic                                 second_valid,
  output logic                                 run_last,
  output logic                                 image_done,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rle2_pkg::IdxW-1:0]            cfg_index,
  input  logic [rle2_pkg::CfgW-1:0]            cfg_data
);

  rle2_pkg::state_t  state, state_next;
  rle2_pkg::phase_t  phase;
  rle2_pkg::cfg_t    cfg;
  rle2_pkg::cursor_t cur, cur_adv;

  logic [6:0] run_remaining;
  logic [7:0] place_cnt;
  logic       packet_end;
  logic       finished;
  logic       in_xfer;
  logic       cfg_xfer;

  assign in_xfer  = in_valid && in_ready;
  assign cfg_xfer = cfg_valid && cfg_ready;

  rle2_advance u_advance (
    .cfg (cfg),
    .cur (cur),
    .nxt (cur_adv)
  );

  always_comb begin
    state_next = state;
    case (state)
      rle2_pkg::ST_IDLE: begin
        if (in_xfer && !finished && phase != rle2_pkg::PH_CONTROL) begin
          state_next = rle2_pkg::ST_FIRST;
        end
      end
      rle2_pkg::ST_FIRST: begin
        state_next = (place_cnt != 8'd1) ? rle2_pkg::ST_SECOND : rle2_pkg::ST_OUT;
      end
      rle2_pkg::ST_SECOND: begin
        state_next = rle2_pkg::ST_OUT;
      end
      rle2_pkg::ST_OUT: begin
        if (out_ready) begin
          state_next = (place_cnt == 8'd0) ? rle2_pkg::ST_IDLE : rle2_pkg::ST_FIRST;
        end
      end
      default: begin
        state_next = rle2_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready  = (state == rle2_pkg::ST_IDLE);
    out_valid = (state == rle2_pkg::ST_OUT);
    // Register writes wait until no byte is being placed.
    cfg_ready = (state == rle2_pkg::ST_IDLE);
    run_last  = (place_cnt == 8'd0);
    image_done = (place_cnt == 8'd0) && packet_end && (cur.field_wraps > 2'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= rle2_pkg::ST_IDLE;
      phase         <= rle2_pkg::PH_CONTROL;
      run_remaining <= '0;
      place_cnt     <= '0;
      packet_end    <= 1'b0;
      finished      <= 1'b0;
      cur           <= '0;
      cfg.x_offset     <= '0;
      cfg.y_offset     <= '0;
      cfg.row_width    <= rle2_pkg::ROW_WIDTH_RESET;
      cfg.row_count    <= rle2_pkg::ROW_COUNT_RESET;
      cfg.pixel_double <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        rle2_pkg::ST_IDLE: begin
          if (in_xfer && !finished) begin
            case (phase)
              rle2_pkg::PH_CONTROL: begin
                run_remaining <= data_byte[6:0] & rle2_pkg::CTRL_LEN_MASK[6:0];
                phase <= ((data_byte & rle2_pkg::CTRL_REPEAT_BIT) != 8'h00) ?
                         rle2_pkg::PH_REPEAT : rle2_pkg::PH_LITERAL;
              end
              rle2_pkg::PH_REPEAT: begin
                pattern    <= data_byte;
                place_cnt  <= {1'b0, run_remaining} + 8'd1;
                packet_end <= 1'b1;
              end
              rle2_pkg::PH_LITERAL: begin
                pattern    <= data_byte;
                place_cnt  <= 8'd1;
                packet_end <= (run_remaining == 7'd0);
                if (run_remaining != 7'd0) begin
                  run_remaining <= run_remaining - 7'd1;
                end
              end
              default: begin
                phase <= rle2_pkg::PH_CONTROL;
              end
            endcase
          end
        end
        rle2_pkg::ST_FIRST: begin
          first_x      <= cur.cx;
          first_y      <= cur.cy;
          second_x     <= '0;
          second_y     <= '0;
          second_valid <= 1'b0;
          cur          <= cur_adv;
          place_cnt    <= place_cnt - 8'd1;
        end
        rle2_pkg::ST_SECOND: begin
          second_x     <= cur.cx;
          second_y     <= cur.cy;
          second_valid <= 1'b1;
          cur          <= cur_adv;
          place_cnt    <= place_cnt - 8'd1;
        end
        rle2_pkg::ST_OUT: begin
          // The final transfer of a packet returns the decoder to control bytes.
          if (out_ready && place_cnt == 8'd0 && packet_end) begin
            phase <= rle2_pkg::PH_CONTROL;
            if (cur.field_wraps > 2'd1) begin
              finished <= 1'b1;
            end
          end
        end
        default: begin
        end
      endcase

      if (cfg_xfer) begin
        case (cfg_index)
          rle2_pkg::REG_X_OFFSET: begin
            cfg.x_offset <= $signed(cfg_data);
            cur.cx       <= rle2_pkg::CoordW'($signed(cfg_data));
          end
          rle2_pkg::REG_Y_OFFSET: begin
            cfg.y_offset <= cfg_data;
            cur.cy       <= {2'b00, cfg_data};
          end
          rle2_pkg::REG_ROW_WIDTH: begin
            cfg.row_width <= cfg_data;
          end
          rle2_pkg::REG_ROW_COUNT: begin
            cfg.row_count <= cfg_data;
          end
          rle2_pkg::REG_PIXEL_DOUBLE: begin
            cfg.pixel_double <= cfg_data[0];
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule
